[hw/rtl/greedy_box_nms_top_assert.svh]
// ----------------------------------------------------------------------------
// greedy_box_nms_top_assert.svh
// Assertion macros shared by the suppression block. Clock clk_i, reset rst_ni.
// ----------------------------------------------------------------------------
`ifndef GREEDY_BOX_NMS_TOP_ASSERT_SVH
`define GREEDY_BOX_NMS_TOP_ASSERT_SVH

// Plain property, checked outside reset
`define GBN_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication, checked outside reset
`define GBN_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

[hw/rtl/gbn_pkg.sv]
// ----------------------------------------------------------------------------
// gbn_pkg
// Types and constants of the greedy box suppression block.
// ----------------------------------------------------------------------------
package gbn_pkg;

  // Controller states
  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SCAN,
    ST_WAIT,
    ST_DECIDE
  } gbn_state_e;

  // Tag that travels with each read through the overlap pipeline
  typedef struct packed {
    logic valid;
    logic last;
  } gbn_tag_t;

  // Register indexes (word address bit 2)
  localparam logic REG_SCORE_THR   = 1'b0;
  localparam logic REG_OVERLAP_THR = 1'b1;

  // Register reset values: 0.8 in Q3.12, 0.5 in Q0.8
  localparam logic [15:0] SCORE_THR_RST   = 16'd3277;
  localparam logic [7:0]  OVERLAP_THR_RST = 8'd128;

endpackage

[hw/rtl/gbn_store.sv]
// ----------------------------------------------------------------------------
// gbn_store
// Box memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module gbn_store #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 72,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[hw/rtl/gbn_iou.sv]
// ----------------------------------------------------------------------------
// gbn_iou
// Four-stage overlap test of a stored box against the reference box:
// intersection*256 > threshold*union, zero union never suppresses.
// ----------------------------------------------------------------------------
module gbn_iou
  import gbn_pkg::*;
#(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned C     = 12,
  localparam int unsigned AW   = $clog2(DEPTH),
  localparam int unsigned DW   = 4 * C + 24
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  gbn_tag_t       tag_i,
  input  logic [AW-1:0]  idx_i,
  input  logic [DW-1:0]  b_data_i,
  input  logic           a_valid_i,
  input  logic [DW-1:0]  a_data_i,
  input  logic [7:0]     overlap_thr_i,
  output gbn_tag_t       tag_o,
  output logic [AW-1:0]  idx_o,
  output logic [DW-1:0]  data_o,
  output logic           supp_o
);

  localparam int unsigned EW = C + 1;        // edge width
  localparam int unsigned IW = 2 * EW;       // intersection / union width
  localparam int unsigned PW = IW + 8;       // scaled products

  logic [C-1:0]    ax, ay, aw, ah, bx, by, bw, bh;
  logic [EW-1:0]   x1, y1, x2, y2, ax2, ay2, bx2, by2, dx, dy;
  logic [PW-1:0]   lhs, rhs;

  gbn_tag_t        tag1_q, tag2_q, tag3_q, tag4_q;
  logic [AW-1:0]   idx1_q, idx2_q, idx3_q, idx4_q;
  logic [DW-1:0]   data1_q, data2_q, data3_q, data4_q;
  logic [EW-1:0]   dx1_q, dy1_q;
  logic [2*C-1:0]  areab1_q, areab2_q, areaa_q;
  logic [IW-1:0]   inter2_q, inter3_q, uni3_q;
  logic            supp4_q;

  assign ax = a_data_i[C-1:0];
  assign ay = a_data_i[2*C-1:C];
  assign aw = a_data_i[3*C-1:2*C];
  assign ah = a_data_i[4*C-1:3*C];
  assign bx = b_data_i[C-1:0];
  assign by = b_data_i[2*C-1:C];
  assign bw = b_data_i[3*C-1:2*C];
  assign bh = b_data_i[4*C-1:3*C];

  // stage 1: edges of the intersection
  always_comb begin
    ax2 = EW'(ax) + EW'(aw);
    ay2 = EW'(ay) + EW'(ah);
    bx2 = EW'(bx) + EW'(bw);
    by2 = EW'(by) + EW'(bh);
    x1  = (ax > bx) ? EW'(ax) : EW'(bx);
    y1  = (ay > by) ? EW'(ay) : EW'(by);
    x2  = (ax2 < bx2) ? ax2 : bx2;
    y2  = (ay2 < by2) ? ay2 : by2;
    dx  = (x2 > x1) ? (x2 - x1) : '0;
    dy  = (y2 > y1) ? (y2 - y1) : '0;
  end

  // stage 4 compare terms
  assign lhs = {inter3_q, 8'd0};
  assign rhs = PW'(uni3_q) * PW'(overlap_thr_i);

  // tags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag1_q <= '0;
      tag2_q <= '0;
      tag3_q <= '0;
      tag4_q <= '0;
    end else begin
      tag1_q <= tag_i;
      tag2_q <= tag1_q;
      tag3_q <= tag2_q;
      tag4_q <= tag3_q;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    areaa_q  <= aw * ah;
    idx1_q   <= idx_i;
    data1_q  <= b_data_i;
    dx1_q    <= dx;
    dy1_q    <= dy;
    areab1_q <= bw * bh;
    idx2_q   <= idx1_q;
    data2_q  <= data1_q;
    inter2_q <= dx1_q * dy1_q;
    areab2_q <= areab1_q;
    idx3_q   <= idx2_q;
    data3_q  <= data2_q;
    inter3_q <= inter2_q;
    uni3_q   <= IW'(areaa_q) + IW'(areab2_q) - inter2_q;
    idx4_q   <= idx3_q;
    data4_q  <= data3_q;
    supp4_q  <= a_valid_i && (uni3_q != '0) && (lhs > rhs);
  end

  assign tag_o  = tag4_q;
  assign idx_o  = idx4_q;
  assign data_o = data4_q;
  assign supp_o = supp4_q;

endmodule

[hw/rtl/greedy_box_nms_top.sv]
// Boxes load at one per cycle; the final box starts the selection walk.
// The walk runs one pass over the stored boxes per kept box plus one; each pass reads every
// stored box through the memory read stage and the four-stage overlap pipeline, then
// decides in ST_DECIDE, which holds while the result output is stalled.
// Reset clears the control state and sets both thresholds to their defaults.
// ----------------------------------------------------------------------------
// greedy_box_nms_top
// Greedy non-maximum suppression: stores a set of boxes, then repeatedly picks
// the best remaining box, emits it and drops later boxes that overlap it.
// ----------------------------------------------------------------------------
`include "greedy_box_nms_top_assert.svh"

module greedy_box_nms_top
  import gbn_pkg::*;
#(
  parameter int unsigned MAX_BOXES  = 64,
  parameter int unsigned COORD_BITS = 12,
  localparam int unsigned DW = 4 * COORD_BITS + 24,
  localparam int unsigned TW = ((DW + 7) / 8) * 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  // input boxes
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [TW-1:0] s_axis_tdata,   // box_x, box_y, box_width, box_height, box_score, box_label
  input  logic          s_axis_tlast,   // last_box
  // results
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [TW-1:0] m_axis_tdata,   // out_x, out_y, out_width, out_height, out_score, out_label
  output logic [1:0]    m_axis_tuser,   // none_kept, overflowed
  output logic          m_axis_tlast,   // last_result
  // configuration
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  localparam int unsigned C  = COORD_BITS;
  localparam int unsigned AW = $clog2(MAX_BOXES);
  localparam int unsigned CW = $clog2(MAX_BOXES + 1);
  localparam int unsigned SL = 4 * C;   // score low bit

  gbn_state_e           state_q, state_d;
  logic [CW-1:0]        count_q, count_d;
  logic                 ovf_q, ovf_d;
  logic [MAX_BOXES-1:0] alive_q, alive_d;
  logic [AW-1:0]        rd_idx_q, rd_idx_d;
  gbn_tag_t             rd_tag_q;
  logic [AW-1:0]        rd_idx_dly_q;
  logic                 pend_valid_q, pend_valid_d;
  logic [DW-1:0]        pend_data_q, pend_data_d;
  logic                 best_found_q, best_found_d;
  logic [DW-1:0]        best_data_q, best_data_d;
  logic [AW-1:0]        best_idx_q, best_idx_d;
  logic                 out_valid_q, out_valid_d;
  logic [DW-1:0]        out_data_q, out_data_d;
  logic                 out_none_q, out_none_d;
  logic                 out_ovf_q, out_ovf_d;
  logic                 out_last_q, out_last_d;
  logic signed [15:0]   score_thr_q;
  logic [7:0]           overlap_thr_q;

  logic                 load_acc, space, out_busy, rd_en, last_issue, wr_en, sel_ok;
  logic [DW-1:0]        rd_data, iou_data;
  gbn_tag_t             iou_tag;
  logic [AW-1:0]        iou_idx;
  logic                 iou_supp;
  logic signed [15:0]   best_score, iou_score;

  // box memory
  gbn_store #(
    .DEPTH (MAX_BOXES),
    .WIDTH (DW)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (count_q[AW-1:0]),
    .wr_data_i (s_axis_tdata[DW-1:0]),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_idx_q),
    .rd_data_o (rd_data)
  );

  // overlap pipeline
  gbn_iou #(
    .DEPTH (MAX_BOXES),
    .C     (C)
  ) u_iou (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .tag_i         (rd_tag_q),
    .idx_i         (rd_idx_dly_q),
    .b_data_i      (rd_data),
    .a_valid_i     (pend_valid_q),
    .a_data_i      (pend_data_q),
    .overlap_thr_i (overlap_thr_q),
    .tag_o         (iou_tag),
    .idx_o         (iou_idx),
    .data_o        (iou_data),
    .supp_o        (iou_supp)
  );

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_SCORE_THR) ? 32'(score_thr_q) : 32'(overlap_thr_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      score_thr_q   <= SCORE_THR_RST;
      overlap_thr_q <= OVERLAP_THR_RST;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == REG_SCORE_THR) begin
        score_thr_q <= pwdata[15:0];
      end else begin
        overlap_thr_q <= pwdata[7:0];
      end
    end
  end

  assign best_score = best_data_q[SL+15:SL];
  assign iou_score  = iou_data[SL+15:SL];

  assign s_axis_tready = (state_q == ST_LOAD);
  assign load_acc      = s_axis_tvalid && s_axis_tready;
  assign space         = (count_q < CW'(MAX_BOXES));
  assign wr_en         = load_acc && space;
  assign out_busy      = out_valid_q && !m_axis_tready;
  assign rd_en         = (state_q == ST_SCAN);
  assign last_issue    = (CW'(rd_idx_q) == count_q - CW'(1));
  assign sel_ok        = best_found_q && (best_score >= score_thr_q);

  // controller: load, scan passes, selection
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    ovf_d        = ovf_q;
    alive_d      = alive_q;
    rd_idx_d     = rd_idx_q;
    pend_valid_d = pend_valid_q;
    pend_data_d  = pend_data_q;
    best_found_d = best_found_q;
    best_data_d  = best_data_q;
    best_idx_d   = best_idx_q;
    out_valid_d  = out_valid_q;
    out_data_d   = out_data_q;
    out_none_d   = out_none_q;
    out_ovf_d    = out_ovf_q;
    out_last_d   = out_last_q;

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    // pass writeback: drop overlapped boxes, track the best remaining one
    if (iou_tag.valid && alive_q[iou_idx]) begin
      if (iou_supp) begin
        alive_d[iou_idx] = 1'b0;
      end else if (!best_found_q || (iou_score > best_score)) begin
        best_found_d = 1'b1;
        best_data_d  = iou_data;
        best_idx_d   = iou_idx;
      end
    end

    case (state_q)
      ST_LOAD: begin
        if (load_acc) begin
          if (space) begin
            alive_d[count_q[AW-1:0]] = 1'b1;
            count_d = count_q + CW'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (s_axis_tlast) begin
            rd_idx_d     = '0;
            best_found_d = 1'b0;
            state_d      = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        rd_idx_d = rd_idx_q + AW'(1);
        if (last_issue) begin
          state_d = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (iou_tag.valid && iou_tag.last) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (!out_busy) begin
          if (sel_ok) begin
            // previous pick is not the final one: release it
            if (pend_valid_q) begin
              out_valid_d = 1'b1;
              out_data_d  = pend_data_q;
              out_none_d  = 1'b0;
              out_ovf_d   = ovf_q;
              out_last_d  = 1'b0;
            end
            pend_valid_d         = 1'b1;
            pend_data_d          = best_data_q;
            alive_d[best_idx_q]  = 1'b0;
            best_found_d         = 1'b0;
            rd_idx_d             = '0;
            state_d              = ST_SCAN;
          end else begin
            // set finished: last pick, or the empty marker
            out_valid_d  = 1'b1;
            out_data_d   = pend_valid_q ? pend_data_q : '0;
            out_none_d   = !pend_valid_q;
            out_ovf_d    = ovf_q;
            out_last_d   = 1'b1;
            alive_d      = '0;
            count_d      = '0;
            ovf_d        = 1'b0;
            pend_valid_d = 1'b0;
            best_found_d = 1'b0;
            state_d      = ST_LOAD;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_LOAD;
      count_q      <= '0;
      ovf_q        <= 1'b0;
      alive_q      <= '0;
      rd_idx_q     <= '0;
      rd_tag_q     <= '0;
      pend_valid_q <= 1'b0;
      best_found_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      ovf_q        <= ovf_d;
      alive_q      <= alive_d;
      rd_idx_q     <= rd_idx_d;
      rd_tag_q     <= '{valid: rd_en, last: rd_en && last_issue};
      pend_valid_q <= pend_valid_d;
      best_found_q <= best_found_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    rd_idx_dly_q <= rd_idx_q;
    pend_data_q  <= pend_data_d;
    best_data_q  <= best_data_d;
    best_idx_q   <= best_idx_d;
    out_data_q   <= out_data_d;
    out_none_q   <= out_none_d;
    out_ovf_q    <= out_ovf_d;
    out_last_q   <= out_last_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = TW'(out_data_q);
  assign m_axis_tuser  = {out_ovf_q, out_none_q};
  assign m_axis_tlast  = out_last_q;

  // checks
  `GBN_ASSERT_IMP(a_drop_flags, load_acc && !space, ##1 ovf_q, "dropped box not flagged")
  `GBN_ASSERT_IMP(a_empty_zero, m_axis_tvalid && m_axis_tuser[0],
                  (out_data_q == '0) && m_axis_tlast, "empty result carries data")
  `GBN_ASSERT_IMP(a_idle_clear, (state_q == ST_LOAD) && (count_q == '0),
                  alive_q == '0, "stale keep flags at start of set")
  `GBN_ASSERT_IMP(a_pipe_pass, iou_tag.valid,
                  (state_q == ST_SCAN) || (state_q == ST_WAIT), "pipeline result outside pass")

endmodule

[sim/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives sets of detection boxes into the suppression block, predicts the
// surviving boxes of each set in order and checks every result request field
// by field. Thresholds are rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module testbench;
  import gbn_pkg::*;

  localparam int unsigned TW        = 72;
  localparam int unsigned CAPACITY  = 64;
  localparam int unsigned DRAIN_GAP = 200;
  localparam longint      CYCLE_CAP = 1000000;
  localparam int unsigned RANDOM_ITEMS = 400;

  typedef struct {
    logic [11:0]        x;
    logic [11:0]        y;
    logic [11:0]        w;
    logic [11:0]        h;
    logic signed [15:0] score;
    logic [7:0]         label;
  } box_t;

  typedef struct {
    box_t box;
    logic none_kept;
    logic overflowed;
    logic last;
  } survivor_t;

  // Predicts survivors of each box set and holds them until they arrive
  class survivor_board;
    logic signed [15:0] score_thr;
    logic [7:0]         overlap_thr;
    box_t               stored[CAPACITY];
    int unsigned        count;
    bit                 overflow;
    survivor_t          pending[$];
    int unsigned        mismatches;

    function new();
      score_thr   = SCORE_THR_RST;
      overlap_thr = OVERLAP_THR_RST;
      count       = 0;
      overflow    = 0;
      mismatches  = 0;
    endfunction

    function bit overlaps_too_much(box_t a, box_t b);
      longint unsigned x1, y1, x2, y2, inter, uni;
      x1 = (a.x > b.x) ? a.x : b.x;
      y1 = (a.y > b.y) ? a.y : b.y;
      x2 = ((a.x + 13'(a.w)) < (b.x + 13'(b.w))) ? a.x + 13'(a.w) : b.x + 13'(b.w);
      y2 = ((a.y + 13'(a.h)) < (b.y + 13'(b.h))) ? a.y + 13'(a.h) : b.y + 13'(b.h);
      inter = 0;
      if (x2 > x1 && y2 > y1) inter = (x2 - x1) * (y2 - y1);
      uni = longint'(a.w) * a.h + longint'(b.w) * b.h - inter;
      if (uni == 0) return 0;
      return inter * 256 > longint'(overlap_thr) * uni;
    endfunction

    // An accepted box; the final one of a set produces the survivors
    function void note_box(box_t b, bit last);
      int unsigned order[CAPACITY];
      bit          keep[CAPACITY];
      int unsigned i, j, emitted;
      survivor_t   s;
      if (count < CAPACITY) begin
        stored[count] = b;
        count++;
      end else begin
        overflow = 1;
      end
      if (!last) return;
      // stable sort, descending score
      for (i = 0; i < count; i++) begin
        j = i;
        while (j > 0 && stored[i].score > stored[order[j-1]].score) begin
          order[j] = order[j-1];
          j--;
        end
        order[j] = i;
        keep[i] = 1;
      end
      emitted = 0;
      for (i = 0; i < count; i++) begin
        if (!keep[i] || stored[order[i]].score < score_thr) continue;
        for (j = i + 1; j < count; j++)
          if (overlaps_too_much(stored[order[i]], stored[order[j]])) keep[j] = 0;
        s.box = stored[order[i]];
        s.none_kept = 0;
        s.overflowed = overflow;
        s.last = 0;
        pending = {pending, s};
        emitted++;
      end
      if (emitted == 0) begin
        s.box = '{default: '0};
        s.none_kept = 1;
        s.overflowed = overflow;
        s.last = 0;
        pending = {pending, s};
      end
      pending[pending.size() - 1].last = 1;
      count = 0;
      overflow = 0;
    endfunction

    function void check_result(box_t b, logic none, logic ovf, logic last);
      survivor_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: x=%0d y=%0d", b.x, b.y);
        return;
      end
      e = pending.pop_front();
      if (b.x !== e.box.x || b.y !== e.box.y || b.w !== e.box.w || b.h !== e.box.h ||
          b.score !== e.box.score || b.label !== e.box.label ||
          none !== e.none_kept || ovf !== e.overflowed || last !== e.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result mismatch: exp x=%0d y=%0d w=%0d h=%0d s=%0d l=%0d n=%0b o=%0b t=%0b",
                   e.box.x, e.box.y, e.box.w, e.box.h, e.box.score, e.box.label,
                   e.none_kept, e.overflowed, e.last);
        if (mismatches <= 10)
          $display("                 got x=%0d y=%0d w=%0d h=%0d s=%0d l=%0d n=%0b o=%0b t=%0b",
                   b.x, b.y, b.w, b.h, b.score, b.label, none, ovf, last);
      end
    endfunction
  endclass

  logic          clk_i;
  logic          rst_ni;
  logic          s_axis_tvalid;
  logic          s_axis_tready;
  logic [TW-1:0] s_axis_tdata;
  logic          s_axis_tlast;
  logic          m_axis_tvalid;
  logic          m_axis_tready;
  logic [TW-1:0] m_axis_tdata;
  logic [1:0]    m_axis_tuser;
  logic          m_axis_tlast;
  logic          psel;
  logic          penable;
  logic          pwrite;
  logic [2:0]    paddr;
  logic [31:0]   pwdata;
  logic [31:0]   prdata;
  logic          pready;

  survivor_board sb;
  longint        cycles = 0;
  int unsigned   boxes_sent;

  greedy_box_nms_top u_top (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Result check at the accepting edge
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_result('{x: m_axis_tdata[11:0], y: m_axis_tdata[23:12],
                        w: m_axis_tdata[35:24], h: m_axis_tdata[47:36],
                        score: m_axis_tdata[63:48], label: m_axis_tdata[71:64]},
                      m_axis_tuser[0], m_axis_tuser[1], m_axis_tlast);
  end

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 94) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // Receiver stalls
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      m_axis_tready = 1'b1;
      repeat ($urandom_range(12, 1)) @(negedge clk_i);
      m_axis_tready = 1'b0;
      repeat (gap_len()) @(negedge clk_i);
    end
  end

  task automatic send_box(box_t b, bit last);
    repeat (gap_len()) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {b.label, b.score, b.h, b.w, b.y, b.x};
    s_axis_tlast  = last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_box(b, last);
    boxes_sent++;
    @(negedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [31:0] value);
    psel    = 1'b1;
    pwrite  = 1'b1;
    penable = 1'b0;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (idx == REG_SCORE_THR) sb.score_thr = value[15:0];
    else sb.overlap_thr = value[7:0];
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // Hold the sender until the block has gone idle
  task automatic drain();
    s_axis_tvalid = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (DRAIN_GAP) @(negedge clk_i);
  endtask

  // One random set; boxes cluster so that overlaps are common
  task automatic send_random_set();
    box_t        b;
    int unsigned n, i, r;
    logic [11:0] cx, cy;
    r = $urandom_range(99);
    n = (r < 80) ? $urandom_range(8, 1) : (r < 96) ? $urandom_range(30, 9)
                                                   : $urandom_range(68, 64);
    cx = 12'($urandom);
    cy = 12'($urandom);
    for (i = 0; i < n; i++) begin
      if ($urandom_range(4) == 0) begin
        b.x = 12'($urandom); b.y = 12'($urandom); b.w = 12'($urandom); b.h = 12'($urandom);
        b.score = 16'($urandom);
      end else begin
        b.x = 12'(cx + $urandom_range(15)); b.y = 12'(cy + $urandom_range(15));
        b.w = 12'($urandom_range(40, 8)); b.h = 12'($urandom_range(40, 8));
        b.score = 16'($urandom_range(12000) - 2000);
      end
      if ($urandom_range(9) == 0) b.score = sb.score_thr;
      b.label = 8'($urandom);
      send_box(b, i == n - 1);
    end
  endtask

  initial begin
    sb = new();
    boxes_sent = 0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tlast = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: ties, identical boxes, edges at the coordinate limit, empty boxes
    send_box('{100, 100, 50, 50, 16'sd8000, 8'd1}, 0);
    send_box('{100, 100, 50, 50, 16'sd8000, 8'd2}, 0);
    send_box('{110, 100, 50, 50, 16'sd9000, 8'd3}, 0);
    send_box('{4095, 4095, 4095, 4095, 16'sd32767, 8'd255}, 0);
    send_box('{4000, 4000, 4095, 4095, 16'sd3277, 8'd0}, 0);
    send_box('{0, 0, 0, 0, 16'sd4000, 8'd4}, 0);
    send_box('{0, 0, 0, 0, 16'sd4000, 8'd5}, 0);
    send_box('{0, 0, 0, 0, -16'sd32768, 8'd6}, 1);
    // Nothing survives
    send_box('{5, 5, 5, 5, 16'sd3276, 8'd7}, 0);
    send_box('{5, 5, 5, 5, -16'sd32768, 8'd8}, 1);
    // Single box, disjoint pair
    send_box('{2048, 1024, 4095, 1, 16'sd20000, 8'd170}, 1);
    send_box('{0, 0, 10, 10, 16'sd5000, 8'd85}, 0);
    send_box('{20, 20, 10, 10, 16'sd5000, 8'd86}, 1);

    // Phases over threshold settings, extremes included
    for (int phase = 0; phase < 5; phase++) begin
      drain();
      case (phase)
        0: begin
          write_reg(REG_SCORE_THR, 32'h0000_8000);
          write_reg(REG_OVERLAP_THR, 32'd0);
        end
        1: begin
          write_reg(REG_SCORE_THR, 32'h0000_7FFF);
          write_reg(REG_OVERLAP_THR, 32'd255);
        end
        2: begin
          write_reg(REG_SCORE_THR, 32'd0);
          write_reg(REG_OVERLAP_THR, 32'd64);
        end
        3: begin
          write_reg(REG_SCORE_THR, $urandom_range(6000));
          write_reg(REG_OVERLAP_THR, $urandom_range(255));
        end
        default: begin
          write_reg(REG_SCORE_THR, 32'(SCORE_THR_RST));
          write_reg(REG_OVERLAP_THR, 32'(OVERLAP_THR_RST));
        end
      endcase
      while (boxes_sent < 13 + (phase + 1) * RANDOM_ITEMS / 5) send_random_set();
    end

    s_axis_tvalid = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (DRAIN_GAP) @(negedge clk_i);
    if (sb.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/gbn_pkg.sv
hw/rtl/gbn_store.sv
hw/rtl/gbn_iou.sv
hw/rtl/greedy_box_nms_top.sv
sim/testbench.sv
